[sv/amrac_pkg.sv]
package amrac_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [7:0]  BCAST_ADDR      = 8'hFF;
    localparam logic [7:0]  ACK_FLAG        = 8'h80;
    localparam logic [7:0]  SEQ_STEP        = 8'h10;
    localparam logic [7:0]  STATS_MARK      = 8'h7E;
    localparam logic [7:0]  OWN_ADDR_RESET  = 8'hFF;
    localparam logic [7:0]  MAX_ATT_RESET   = 8'd1;
    localparam logic [15:0] ACK_WAIT_RESET  = 16'd3220;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_TX_DONE = 2'd1,
        OP_RX      = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_REPORT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_ALOHA_MODE = 2'd0,
        REG_OWN_ADDR   = 2'd1,
        REG_MAX_ATT    = 2'd2,
        REG_ACK_WAIT   = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_TX_DATA  = 4'b0010,
        PH_WAIT_ACK = 4'b0100,
        PH_TX_PLAIN = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] dest_addr;
        logic [7:0] src_addr;
        logic [7:0] type_seq;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  out_dest;
        logic [7:0]  out_src;
        logic [7:0]  out_type;
        logic [7:0]  attempts_used;
        logic [31:0] elapsed;
    } out_item_t;

    typedef struct packed {
        logic        aloha_mode;
        logic [7:0]  own_address;
        logic [7:0]  max_attempts;
        logic [15:0] ack_wait_ticks;
    } cfg_t;

endpackage

[sv/amrac_cfg_regs.sv]
module amrac_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [amrac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [amrac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output amrac_pkg::cfg_t                      cfg
);
    import amrac_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_ALOHA_MODE: cfg_next.aloha_mode     = cfg_wdata[0];
                REG_OWN_ADDR:   cfg_next.own_address    = cfg_wdata[7:0];
                REG_MAX_ATT:    cfg_next.max_attempts   = cfg_wdata[7:0];
                REG_ACK_WAIT:   cfg_next.ack_wait_ticks = cfg_wdata[15:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.aloha_mode     <= 1'b0;
            cfg_reg.own_address    <= OWN_ADDR_RESET;
            cfg_reg.max_attempts   <= MAX_ATT_RESET;
            cfg_reg.ack_wait_ticks <= ACK_WAIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/amrac_engine.sv]
module amrac_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  amrac_pkg::cfg_t       cfg,
    input  logic                  in_fire,
    input  amrac_pkg::in_item_t   in_item,
    output logic                  res_valid,
    output amrac_pkg::out_item_t  res_item
);
    import amrac_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic        ack_busy_reg,  ack_busy_next;
    logic [7:0]  attempt_reg,   attempt_next;
    logic [7:0]  pend_dest_reg, pend_dest_next;
    logic [7:0]  pend_type_reg, pend_type_next;
    logic [31:0] elapsed_reg,   elapsed_next;
    logic [15:0] wait_reg,      wait_next;

    logic       timeout;
    logic       start_data;
    logic       plain_data;
    logic       send_ack;
    logic       report;
    logic [7:0] report_att;
    logic [2:0] want_seq;

    assign want_seq = pend_type_reg[6:4] + 3'd1;

    always_comb begin
        phase_next     = phase_reg;
        ack_busy_next  = ack_busy_reg;
        attempt_next   = attempt_reg;
        pend_dest_next = pend_dest_reg;
        pend_type_next = pend_type_reg;
        elapsed_next   = elapsed_reg;
        wait_next      = wait_reg;
        timeout        = 1'b0;
        start_data     = 1'b0;
        plain_data     = 1'b0;
        send_ack       = 1'b0;
        report         = 1'b0;
        report_att     = attempt_reg;
        res_valid      = 1'b0;
        res_item       = '0;

        if (in_fire) begin
            unique case (op_t'(in_item.op))
                OP_SEND: begin
                    if (phase_reg == PH_IDLE && !ack_busy_reg) begin
                        pend_dest_next = in_item.dest_addr;
                        pend_type_next = in_item.type_seq;
                        attempt_next   = 8'd0;
                        elapsed_next   = 32'd0;
                        wait_next      = 16'd0;
                        if (!cfg.aloha_mode) begin
                            phase_next = PH_TX_PLAIN;
                            plain_data = 1'b1;
                        end else if (cfg.max_attempts == 8'd0) begin
                            report     = 1'b1;
                            report_att = 8'd0;
                        end else begin
                            start_data = 1'b1;
                        end
                    end
                end
                OP_TX_DONE: begin
                    if (ack_busy_reg) begin
                        ack_busy_next = 1'b0;
                        if (phase_reg == PH_WAIT_ACK && wait_reg >= cfg.ack_wait_ticks) begin
                            timeout = 1'b1;
                        end
                    end else if (phase_reg == PH_TX_PLAIN) begin
                        phase_next = PH_IDLE;
                    end else if (phase_reg == PH_TX_DATA) begin
                        if (pend_dest_reg == BCAST_ADDR) begin
                            report = 1'b1;
                        end else begin
                            phase_next = PH_WAIT_ACK;
                            wait_next  = 16'd0;
                            // Only a zero wait setting expires at once.
                            timeout    = (cfg.ack_wait_ticks == 16'd0);
                        end
                    end
                end
                OP_RX: begin
                    if (cfg.aloha_mode && !ack_busy_reg && phase_reg != PH_TX_DATA
                            && phase_reg != PH_TX_PLAIN
                            && in_item.dest_addr != BCAST_ADDR) begin
                        if (in_item.type_seq[7]) begin
                            if (phase_reg == PH_WAIT_ACK && wait_reg < cfg.ack_wait_ticks
                                    && in_item.type_seq[6:4] == want_seq) begin
                                report = 1'b1;
                            end
                        end else begin
                            ack_busy_next = 1'b1;
                            send_ack      = 1'b1;
                        end
                    end
                end
                OP_TICK: begin
                    if (phase_reg == PH_TX_DATA || phase_reg == PH_WAIT_ACK) begin
                        if (elapsed_reg != '1) begin
                            elapsed_next = elapsed_reg + 32'd1;
                        end
                    end
                    if (phase_reg == PH_WAIT_ACK) begin
                        if (wait_reg != '1) begin
                            wait_next = wait_reg + 16'd1;
                        end
                        timeout = (wait_next >= cfg.ack_wait_ticks) && !ack_busy_reg;
                    end
                end
                default: begin
                end
            endcase

            if (timeout) begin
                if (attempt_reg < cfg.max_attempts) begin
                    start_data = 1'b1;
                end else begin
                    report     = 1'b1;
                    report_att = 8'd0;
                end
            end

            if (start_data) begin
                attempt_next = attempt_next + 8'd1;
                phase_next   = PH_TX_DATA;
            end
            if (report) begin
                phase_next = PH_IDLE;
                wait_next  = 16'd0;
            end

            res_valid = start_data || plain_data || send_ack || report;
            res_item.out_src = cfg.own_address;
            if (start_data || plain_data) begin
                res_item.kind     = KIND_DATA;
                res_item.out_dest = pend_dest_next;
                res_item.out_type = pend_type_next;
            end else if (send_ack) begin
                res_item.kind     = KIND_ACK;
                res_item.out_dest = in_item.src_addr;
                res_item.out_type = ACK_FLAG | (in_item.type_seq + SEQ_STEP);
            end else if (report) begin
                res_item.kind          = KIND_REPORT;
                res_item.out_dest      = cfg.own_address;
                res_item.out_type      = STATS_MARK;
                res_item.attempts_used = report_att;
                res_item.elapsed       = elapsed_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            ack_busy_reg  <= 1'b0;
            attempt_reg   <= 8'd0;
            pend_dest_reg <= 8'd0;
            pend_type_reg <= 8'd0;
            elapsed_reg   <= 32'd0;
            wait_reg      <= 16'd0;
        end else begin
            phase_reg     <= phase_next;
            ack_busy_reg  <= ack_busy_next;
            attempt_reg   <= attempt_next;
            pend_dest_reg <= pend_dest_next;
            pend_type_reg <= pend_type_next;
            elapsed_reg   <= elapsed_next;
            wait_reg      <= wait_next;
        end
    end

endmodule

[sv/amrac_out_buf.sv]
module amrac_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  amrac_pkg::out_item_t  push_item,
    output logic                  can_take,
    output logic                  m_valid,
    input  logic                  m_ready,
    output amrac_pkg::out_item_t  m_data
);
    import amrac_pkg::*;

    logic      head_valid_reg, head_valid_next;
    out_item_t head_reg,       head_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_reg,       skid_next;
    logic      pop;

    assign pop = head_valid_reg && m_ready;

    always_comb begin
        head_valid_next = head_valid_reg;
        head_next       = head_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // No push can arrive while the skid entry is occupied.
            if (pop) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!head_valid_reg || pop) begin
                head_next       = push_item;
                head_valid_next = 1'b1;
            end else begin
                skid_next       = push_item;
                skid_valid_next = 1'b1;
            end
        end else if (pop) begin
            head_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign can_take = !skid_valid_reg;
    assign m_valid  = head_valid_reg;
    assign m_data   = head_reg;

endmodule

[sv/aloha_mac_retry_ack_controller_core.sv]
// Channel   Direction  Ports                     Beat
// -------   ---------  ------------------------  ---------------------------------
// s_        in         s_valid s_ready s_data    one MAC event (send, tx done, rx, tick)
// m_        out        m_valid m_ready m_data    one data start, ACK start or report
// cfg_      in         cfg_we cfg_index cfg_wdata one register write, no handshake
//
// One event beat can be taken every cycle while s_ready is high; its result, if any,
// shows on m_ the cycle after acceptance, or later while older results await the sink.
// The event is decoded and the MAC state updated in a single pass at acceptance.
// The result lands in a two-entry output buffer, so s_ready drops only when both
// entries hold results that the sink has not taken.
// Reset is synchronous on aresetn low and returns all state to idle with reset config.
module aloha_mac_retry_ack_controller_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  amrac_pkg::in_item_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output amrac_pkg::out_item_t              m_data,
    input  logic                              cfg_we,
    input  logic [amrac_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [amrac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import amrac_pkg::*;

    cfg_t      cfg;
    logic      in_fire;
    logic      res_valid;
    out_item_t res_item;
    logic      buf_can_take;

    // An event is consumed exactly when the output buffer has room for
    // whatever result it might produce.
    assign s_ready = buf_can_take;
    assign in_fire = s_valid && buf_can_take;

    // Configuration registers; the user must write them only while the block is idle, as the block does not enforce it.
    amrac_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // MAC state: phase, ACK transmit flag, attempt count, pending frame and
    // the elapsed and ACK wait tick counters, plus the result decision.
    amrac_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // Result register with a skid entry behind it.
    amrac_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_valid),
        .push_item (res_item),
        .can_take  (buf_can_take),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[sv/amrac_checker.sv]
module amrac_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input amrac_pkg::out_item_t              m_data
);
    import amrac_pkg::*;

    // After reset no result is shown.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind == KIND_DATA || m_data.kind == KIND_ACK
                     || m_data.kind == KIND_REPORT))
        else $error("unknown result kind");

    // Transmission starts carry no statistics.
    a_no_stats: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_REPORT
            |-> m_data.attempts_used == 8'd0 && m_data.elapsed == 32'd0)
        else $error("statistics on a transmission start");

    // Reports are marked and addressed to the node itself; ACKs carry the ACK flag.
    a_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.kind != KIND_REPORT
                     || (m_data.out_type == STATS_MARK && m_data.out_dest == m_data.out_src))
                 && (m_data.kind != KIND_ACK || m_data.out_type[7]))
        else $error("report or ACK byte malformed");

endmodule

bind aloha_mac_retry_ack_controller_core amrac_checker u_amrac_checker (.*);
